>>> design/fcte_pkg.sv
package fcte_pkg;

   // link values with a fixed meaning
   localparam logic [31:0] LINK_EOC   = 32'h0FFF_FFFF;
   localparam logic [31:0] LINK_LIMIT = 32'h0FFF_FFF8;
   localparam logic [31:0] LINK_FREE  = 32'h0000_0000;
   localparam logic [31:0] FIRST_DATA = 32'd2;

   // reset value of the allocator range register
   localparam logic [11:0] CLUSTERS_RESET = 12'd4094;

   // register index on the csr port (paddr[2])
   localparam logic CSR_IDX_CLUSTERS_IN_USE = 1'b0;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
   localparam logic [1:0] STATUS_WALK_CUT = 2'd2;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_ALLOC = 2'd2,
      OP_FREE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_ALLOC,
      ST_FREE,
      ST_DONE
   } state_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [27:0] cluster_number;
      logic [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic [12:0] freed_count;
      logic [1:0]  status;
   } rsp_type;

endpackage

>>> design/fat_cluster_table_engine.sv
// ops: read, write, allocate (a scan of up to clusters_in_use entries) and free (a walk
// along the chain); all walks go one table entry per cycle
// through the table memory (one read port and one write port, one access each per cycle)
// one word in flight at a time; a finished result waits in the output register
// while the next word is accepted
// after reset a clearing pass writes zero to all TABLE_DEPTH entries, one per
// cycle, before the first word is taken; csr writes are taken throughout
module fat_cluster_table_engine #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  fcte_pkg::req_type req_word,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fcte_pkg::rsp_type rsp_word,
   // csr port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW  = (AW + 1 > 13) ? AW + 1 : 13;
   localparam int STW = $clog2(TABLE_DEPTH + 1);

   // registers
   fcte_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [CW-1:0]  scan_ff, scan_in;
   logic [AW-1:0]  chk_ff, chk_in;
   logic           chk_vld_ff, chk_vld_in;
   logic [31:0]    cur_ff, cur_in;
   logic [STW-1:0] steps_ff, steps_in;
   logic           fwd_ff, fwd_in;
   logic [31:0]    result_ff, result_in;
   logic [12:0]    freed_ff, freed_in;
   logic [1:0]     status_ff, status_in;
   logic           rsp_vld_ff, rsp_vld_in;
   fcte_pkg::rsp_type rsp_ff, rsp_in;
   logic [11:0]    cfg_ff, cfg_in;

   // table memory
   logic [31:0]    mem [TABLE_DEPTH];
   logic [31:0]    mem_rdata_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [31:0]    mem_wdata;
   logic [AW-1:0]  mem_raddr;

   // helpers
   logic           req_take;
   logic           slot_free;
   logic           cfg_wr;
   logic [CW-1:0]  scan_end;
   logic [CW-1:0]  scan_limit;
   logic [31:0]    link_next;
   logic           req_in_table;
   logic           cur_in_table;
   logic           cur_walkable;

   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_vld_ff || !rsp_stall;
   assign cfg_wr    = psel && penable && pwrite && pready;

   assign scan_end     = CW'(cfg_ff) + CW'(fcte_pkg::FIRST_DATA);
   assign scan_limit   = (scan_end < CW'(TABLE_DEPTH)) ? scan_end : CW'(TABLE_DEPTH);
   assign req_in_table = req_word.cluster_number < 28'(TABLE_DEPTH);
   assign cur_in_table = cur_ff < 32'(TABLE_DEPTH);
   assign cur_walkable = (cur_ff >= fcte_pkg::FIRST_DATA) && (cur_ff < fcte_pkg::LINK_LIMIT);
   // an entry zeroed in the previous cycle reads back as free
   assign link_next    = fwd_ff ? fcte_pkg::LINK_FREE : mem_rdata_ff;

   // csr port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == fcte_pkg::CSR_IDX_CLUSTERS_IN_USE) ? {20'd0, cfg_ff} : 32'd0;
   assign cfg_in = (cfg_wr && paddr[2] == fcte_pkg::CSR_IDX_CLUSTERS_IN_USE)
                   ? pwdata[11:0] : cfg_ff;

   // handshake outputs
   assign req_stall = (state_ff != fcte_pkg::ST_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_ff;

   // next state, memory access and result
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      scan_in    = scan_ff;
      chk_in     = chk_ff;
      chk_vld_in = chk_vld_ff;
      cur_in     = cur_ff;
      steps_in   = steps_ff;
      fwd_in     = 1'b0;
      result_in  = result_ff;
      freed_in   = freed_ff;
      status_in  = status_ff;
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      rsp_in     = rsp_ff;
      mem_we     = 1'b0;
      mem_waddr  = cur_ff[AW-1:0];
      mem_wdata  = fcte_pkg::LINK_FREE;
      mem_raddr  = cur_ff[AW-1:0];

      unique case (state_ff)
         fcte_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = fcte_pkg::ST_IDLE;
            end
         end

         fcte_pkg::ST_IDLE: begin
            mem_raddr = req_word.cluster_number[AW-1:0];
            if (req_take) begin
               cur_in    = {4'd0, req_word.cluster_number};
               result_in = 32'd0;
               freed_in  = 13'd0;
               status_in = fcte_pkg::STATUS_OK;
               steps_in  = '0;
               unique case (req_word.opcode)
                  fcte_pkg::OP_READ: begin
                     state_in = fcte_pkg::ST_READ;
                  end
                  fcte_pkg::OP_WRITE: begin
                     mem_we    = req_in_table;
                     mem_waddr = req_word.cluster_number[AW-1:0];
                     mem_wdata = req_word.entry_value;
                     state_in  = fcte_pkg::ST_DONE;
                  end
                  fcte_pkg::OP_ALLOC: begin
                     scan_in    = CW'(fcte_pkg::FIRST_DATA);
                     chk_vld_in = 1'b0;
                     state_in   = fcte_pkg::ST_ALLOC;
                  end
                  fcte_pkg::OP_FREE: begin
                     state_in = fcte_pkg::ST_FREE;
                  end
               endcase
            end
         end

         fcte_pkg::ST_READ: begin
            result_in = cur_in_table ? mem_rdata_ff : fcte_pkg::LINK_EOC;
            state_in  = fcte_pkg::ST_DONE;
         end

         // reads are issued one per cycle, each checked in the next cycle
         fcte_pkg::ST_ALLOC: begin
            mem_raddr = scan_ff[AW-1:0];
            if (chk_vld_ff && mem_rdata_ff == fcte_pkg::LINK_FREE) begin
               mem_we    = 1'b1;
               mem_waddr = chk_ff;
               mem_wdata = fcte_pkg::LINK_EOC;
               result_in = 32'(chk_ff);
               state_in  = fcte_pkg::ST_DONE;
            end else if (scan_ff < scan_limit) begin
               chk_in     = scan_ff[AW-1:0];
               chk_vld_in = 1'b1;
               scan_in    = scan_ff + CW'(1);
            end else if (chk_vld_ff) begin
               chk_vld_in = 1'b0;
            end else begin
               status_in = fcte_pkg::STATUS_NO_FREE;
               state_in  = fcte_pkg::ST_DONE;
            end
         end

         // one link per cycle: zero the entry, read the next one
         fcte_pkg::ST_FREE: begin
            if (!cur_walkable) begin
               state_in = fcte_pkg::ST_DONE;
            end else if (steps_ff == STW'(TABLE_DEPTH)) begin
               status_in = fcte_pkg::STATUS_WALK_CUT;
               state_in  = fcte_pkg::ST_DONE;
            end else if (cur_in_table) begin
               mem_we    = 1'b1;
               mem_waddr = cur_ff[AW-1:0];
               mem_wdata = fcte_pkg::LINK_FREE;
               mem_raddr = link_next[AW-1:0];
               fwd_in    = (link_next == cur_ff);
               cur_in    = link_next;
               freed_in  = freed_ff + 13'd1;
               steps_in  = steps_ff + STW'(1);
            end else begin
               cur_in   = fcte_pkg::LINK_EOC;
               steps_in = steps_ff + STW'(1);
            end
         end

         fcte_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_vld_in          = 1'b1;
               rsp_in.result_value = result_ff;
               rsp_in.freed_count  = freed_ff;
               rsp_in.status       = status_ff;
               state_in            = fcte_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fcte_pkg::ST_IDLE;
         end
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fcte_pkg::ST_CLEAR;
         clr_ff     <= '0;
         chk_vld_ff <= 1'b0;
         fwd_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
         cfg_ff     <= fcte_pkg::CLUSTERS_RESET;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         chk_vld_ff <= chk_vld_in;
         fwd_ff     <= fwd_in;
         rsp_vld_ff <= rsp_vld_in;
         cfg_ff     <= cfg_in;
      end
      scan_ff   <= scan_in;
      chk_ff    <= chk_in;
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
      result_ff <= result_in;
      freed_ff  <= freed_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

endmodule
